[rtl/ste_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table engine package
// Operation and status codes, fixed field widths and the per-cell control
// struct that are shared across the project.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Action broadcast to every cell for the transfer being taken.
    typedef struct packed {
        logic ins;
        logic rem;
        logic rd;
    } t_cell_ctl;

endpackage

[rtl/ste_if.sv]
// ----------------------------------------------------------------------------
// Sorted table engine channels
// Valid/ready interfaces for the request and the result streams.
// ----------------------------------------------------------------------------
interface ste_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [ste_pkg::OP_W-1:0]    operation;
    logic signed [VALUE_BITS-1:0] value;
    logic [ste_pkg::INDEX_W-1:0] index;

    modport source (output valid, output operation, output value, output index,
                    input ready);
    modport sink   (input valid, input operation, input value, input index,
                    output ready);
endinterface

interface ste_out_if #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_W    = 7
);
    logic                         valid;
    logic                         ready;
    logic [ste_pkg::STATUS_W-1:0] status;
    logic signed [VALUE_BITS-1:0] read_value;
    logic [COUNT_W-1:0]           entry_count;

    modport source (output valid, output status, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input entry_count, output ready);
endinterface

[rtl/sorted_table_engine.sv]
// ----------------------------------------------------------------------------
// Sorted table engine
// Ascending table of signed values with append, get and remove by position.
// ----------------------------------------------------------------------------
// The engine holds one request at a time: the table cells shift or capture in
// the cycle of the transfer, and the following cycle merges the read selection
// through an OR tree into the result register. A new request is taken as the
// result is transferred, and not while a request is still being finished. The
// table lives in a row of TABLE_DEPTH cells, one entry each; entries above the
// count are unspecified.
// ----------------------------------------------------------------------------
module sorted_table_engine #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_BITS  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ste_in_if.sink    i_in,
    ste_out_if.source o_out
);

    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (COUNT_W > ste_pkg::INDEX_W) ? COUNT_W : ste_pkg::INDEX_W;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

    logic                          r_busy;
    logic                          r_out_valid;
    logic [COUNT_W-1:0]            r_count;
    logic [COUNT_W-1:0]            n_count;
    logic [ste_pkg::STATUS_W-1:0]  r_status;
    logic [ste_pkg::STATUS_W-1:0]  n_status;
    logic [ste_pkg::STATUS_W-1:0]  r_out_status;
    logic [VALUE_BITS-1:0]         r_out_value;
    logic [COUNT_W-1:0]            r_out_count;
    ste_pkg::t_cell_ctl            w_ctl;
    logic                          w_in_xfer;
    logic                          w_idx_ok;
    logic [CMP_W-1:0]              w_count_x;
    logic [CMP_W-1:0]              w_index_x;
    logic [VALUE_BITS-1:0]         w_read;

    logic signed [VALUE_BITS-1:0]  w_entry [TABLE_DEPTH];
    logic                          w_gt    [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]         w_sel   [TABLE_DEPTH];

    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_in_xfer  = i_in.valid && i_in.ready;

    assign w_count_x = CMP_W'(r_count);
    assign w_index_x = CMP_W'(i_in.index);
    assign w_idx_ok  = (w_index_x < w_count_x);

    always_comb begin
        w_ctl    = '0;
        n_status = ste_pkg::ST_OK;
        n_count  = r_count;
        case (i_in.operation)
            ste_pkg::OP_APPEND: begin
                if (r_count == FULL_COUNT) begin
                    n_status = ste_pkg::ST_FULL;
                end else begin
                    w_ctl.ins = w_in_xfer;
                    n_count   = r_count + COUNT_W'(1);
                end
            end
            ste_pkg::OP_GET: begin
                if (w_idx_ok) begin
                    w_ctl.rd = w_in_xfer;
                end else begin
                    n_status = ste_pkg::ST_RANGE;
                end
            end
            ste_pkg::OP_REMOVE: begin
                if (w_idx_ok) begin
                    w_ctl.rem = w_in_xfer;
                    n_count   = r_count - COUNT_W'(1);
                end else begin
                    n_status = ste_pkg::ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic signed [VALUE_BITS-1:0] w_prev_entry;
            logic                         w_prev_gt;
            logic signed [VALUE_BITS-1:0] w_next_entry;

            if (g == 0) begin : g_first
                assign w_prev_entry = '0;
                assign w_prev_gt    = 1'b0;
            end else begin : g_mid
                assign w_prev_entry = w_entry[g-1];
                assign w_prev_gt    = w_gt[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_next_entry = '0;
            end else begin : g_more
                assign w_next_entry = w_entry[g+1];
            end

            ste_cell #(
                .POS        (g),
                .VALUE_BITS (VALUE_BITS),
                .CMP_W      (CMP_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_value      (i_in.value),
                .i_count      (w_count_x),
                .i_index      (w_index_x),
                .i_prev_entry (w_prev_entry),
                .i_prev_gt    (w_prev_gt),
                .i_next_entry (w_next_entry),
                .o_entry      (w_entry[g]),
                .o_gt         (w_gt[g]),
                .o_sel        (w_sel[g])
            );
        end
    endgenerate

    ste_or_tree #(
        .LEAVES (TABLE_DEPTH),
        .WIDTH  (VALUE_BITS)
    ) u_or_tree (
        .i_leaf (w_sel),
        .o_word (w_read)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_busy <= w_in_xfer;
            if (w_in_xfer) begin
                r_count <= n_count;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_status <= n_status;
        end
        if (r_busy) begin
            r_out_status <= r_status;
            r_out_value  <= w_read;
            r_out_count  <= r_count;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.read_value  = r_out_value;
    assign o_out.entry_count = r_out_count;

    // The count can never pass the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count above table depth");

    // A request in flight always lands in the result register next cycle.
    a_busy_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> r_out_valid)
        else $error("result not loaded after request");

    // A full report is only given with a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ste_pkg::ST_FULL)) |->
        (o_out.entry_count == FULL_COUNT))
        else $error("full status with room left");

    // A transfer is never taken while the previous request is being finished.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !i_in.ready)
        else $error("request taken while busy");

endmodule

[rtl/ste_cell.sv]
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table position. Compares its entry with the broadcast value and
// shifts up on insert or down on remove, taking data from its neighbors.
// ----------------------------------------------------------------------------
module ste_cell #(
    parameter int POS        = 0,
    parameter int VALUE_BITS = 32,
    parameter int CMP_W      = 7
) (
    input  logic                         i_clk,
    input  ste_pkg::t_cell_ctl           i_ctl,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic [CMP_W-1:0]             i_count,
    input  logic [CMP_W-1:0]             i_index,
    input  logic signed [VALUE_BITS-1:0] i_prev_entry,
    input  logic                         i_prev_gt,
    input  logic signed [VALUE_BITS-1:0] i_next_entry,
    output logic signed [VALUE_BITS-1:0] o_entry,
    output logic                         o_gt,
    output logic [VALUE_BITS-1:0]        o_sel
);

    localparam logic [CMP_W-1:0] MY_POS = CMP_W'(POS);

    logic signed [VALUE_BITS-1:0] r_entry;
    logic signed [VALUE_BITS-1:0] n_entry;
    logic [VALUE_BITS-1:0]        r_sel;
    logic                         w_live;

    assign w_live = (MY_POS < i_count);
    // Entries are ascending, so the cells holding larger values form a run
    // at the top of the live region; the insert takes the lowest cell of that run, which moves up.
    assign o_gt   = w_live && (r_entry > i_value);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_entry = i_prev_entry;
            end else if (o_gt || (MY_POS == i_count)) begin
                n_entry = i_value;
            end
        end else if (i_ctl.rem) begin
            if (MY_POS >= i_index) begin
                n_entry = i_next_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_sel   <= (i_ctl.rd && (MY_POS == i_index)) ? r_entry : '0;
    end

    assign o_entry = r_entry;
    assign o_sel   = r_sel;

endmodule

[rtl/ste_or_tree.sv]
// ----------------------------------------------------------------------------
// Sorted table read combiner
// Balanced OR tree that merges the per-cell read selections into one word.
// ----------------------------------------------------------------------------
module ste_or_tree #(
    parameter int LEAVES = 64,
    parameter int WIDTH  = 32
) (
    input  logic [WIDTH-1:0] i_leaf [LEAVES],
    output logic [WIDTH-1:0] o_word
);

    localparam int SPAN = 2 ** $clog2(LEAVES);

    logic [WIDTH-1:0] w_node [2*SPAN];

    genvar g;
    generate
        for (g = 0; g < SPAN; g++) begin : g_leaf
            if (g < LEAVES) begin : g_used
                assign w_node[SPAN+g] = i_leaf[g];
            end else begin : g_pad
                assign w_node[SPAN+g] = '0;
            end
        end
        for (g = 1; g < SPAN; g++) begin : g_inner
            assign w_node[g] = w_node[2*g] | w_node[2*g+1];
        end
    endgenerate

    assign w_node[0] = '0;
    assign o_word    = w_node[1] | w_node[0];

endmodule
